// ===== rtl/lsc_pkg.sv =====
// lsc_pkg: shared types and constants of the 3d segment clipper
// no dependencies
package lsc_pkg;

    localparam int LANES  = 6;
    localparam int AXES   = 3;
    localparam int COLOR_W = 16;

    // per boundary test status carried beside the divider lanes
    typedef struct packed {
        logic den_zero;
        logic den_pos;
        logic num_pos;
        logic neg;
        logic sat;
    } lane_flags_t;

endpackage

// ===== rtl/lsc_div_cell.sv =====
// lsc_div_cell: one restoring division step for all six boundary lanes
// depends on lsc_pkg
module lsc_div_cell #(
    parameter int C = 16,
    parameter int F = 16,
    parameter int SIDE_W = 128
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [lsc_pkg::LANES-1:0][C:0]        in_den,
    input  logic [lsc_pkg::LANES-1:0][C+1:0]      in_rem,
    input  logic [lsc_pkg::LANES-1:0][F:0]        in_quo,
    input  lsc_pkg::lane_flags_t [lsc_pkg::LANES-1:0] in_flags,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [lsc_pkg::LANES-1:0][C:0]        out_den,
    output logic [lsc_pkg::LANES-1:0][C+1:0]      out_rem,
    output logic [lsc_pkg::LANES-1:0][F:0]        out_quo,
    output lsc_pkg::lane_flags_t [lsc_pkg::LANES-1:0] out_flags,
    output logic [SIDE_W-1:0]                     out_side
);
    import lsc_pkg::*;

    logic                      valid_reg;
    logic [LANES-1:0][C+1:0]   rem_next;
    logic [LANES-1:0][F:0]     quo_next;
    logic [LANES-1:0][C:0]     den_reg;
    logic [LANES-1:0][C+1:0]   rem_reg;
    logic [LANES-1:0][F:0]     quo_reg;
    lane_flags_t [LANES-1:0]   flags_reg;
    logic [SIDE_W-1:0]         side_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic          bit_q;
            logic [C+1:0]  diff;
            bit_q = in_rem[l] >= {1'b0, in_den[l]};
            diff  = bit_q ? in_rem[l] - {1'b0, in_den[l]} : in_rem[l];
            rem_next[l] = {diff[C:0], 1'b0};
            quo_next[l] = {in_quo[l][F-1:0], bit_q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            den_reg   <= in_den;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/lsc_edge_cell.sv =====
// lsc_edge_cell: one boundary test updating entry and exit parameters
// depends on lsc_pkg
module lsc_edge_cell #(
    parameter int F = 16,
    parameter int SIDE_W = 128,
    parameter int IDX = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [lsc_pkg::LANES-1:0][F:0]        in_quo,
    input  lsc_pkg::lane_flags_t [lsc_pkg::LANES-1:0] in_flags,
    input  logic [F:0]                            in_te,
    input  logic [F:0]                            in_tl,
    input  logic                                  in_vis,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [lsc_pkg::LANES-1:0][F:0]        out_quo,
    output lsc_pkg::lane_flags_t [lsc_pkg::LANES-1:0] out_flags,
    output logic [F:0]                            out_te,
    output logic [F:0]                            out_tl,
    output logic                                  out_vis,
    output logic [SIDE_W-1:0]                     out_side
);
    import lsc_pkg::*;

    logic                    valid_reg;
    logic [LANES-1:0][F:0]   quo_reg;
    lane_flags_t [LANES-1:0] flags_reg;
    logic [F:0]              te_reg, te_next;
    logic [F:0]              tl_reg, tl_next;
    logic                    vis_reg, vis_next;
    logic [SIDE_W-1:0]       side_reg;

    logic [F:0]              qmag;
    logic signed [F+1:0]     qs, t, tes, tls;
    lane_flags_t             fl;

    always_comb begin
        fl   = in_flags[IDX];
        qmag = fl.sat ? {(F+1){1'b1}} : in_quo[IDX];
        qs   = $signed({1'b0, qmag});
        t    = fl.neg ? -qs : qs;
        tes  = $signed({1'b0, in_te});
        tls  = $signed({1'b0, in_tl});
        te_next  = in_te;
        tl_next  = in_tl;
        vis_next = in_vis;
        if (in_vis) begin
            if (fl.den_zero) begin
                if (fl.num_pos) begin
                    vis_next = 1'b0;
                end
            end else if (fl.den_pos) begin
                if (t > tls) begin
                    vis_next = 1'b0;
                end else if (t > tes) begin
                    te_next = t[F:0];
                end
            end else begin
                if (t < tes) begin
                    vis_next = 1'b0;
                end else if (t < tls) begin
                    tl_next = t[F:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            quo_reg   <= in_quo;
            flags_reg <= in_flags;
            te_reg    <= te_next;
            tl_reg    <= tl_next;
            vis_reg   <= vis_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;
    assign out_te    = te_reg;
    assign out_tl    = tl_reg;
    assign out_vis   = vis_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/lsc_lerp.sv =====
// lsc_lerp: registered products d*t and final endpoint selection
// depends on lsc_pkg
module lsc_lerp #(
    parameter int C = 16,
    parameter int F = 16,
    parameter int SIDE_W = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [F:0]            in_te,
    input  logic [F:0]            in_tl,
    input  logic                  in_vis,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic                  out_vis,
    output logic [SIDE_W-1:0]     out_data
);
    import lsc_pkg::*;

    localparam int PW = C + F + 3;

    logic                             valid_reg;
    logic                             vis_reg;
    logic [SIDE_W-1:0]                side_reg;
    logic [AXES-1:0][PW-1:0]          pe_reg, pe_next;
    logic [AXES-1:0][PW-1:0]          pl_reg, pl_next;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            logic signed [C:0]    d;
            logic signed [PW-1:0] dx, tex, tlx;
            d   = $signed({in_side[(AXES+k)*C+C-1], in_side[(AXES+k)*C +: C]})
                - $signed({in_side[k*C+C-1], in_side[k*C +: C]});
            dx  = d;
            tex = $signed({{(PW-F-1){1'b0}}, in_te});
            tlx = $signed({{(PW-F-1){1'b0}}, in_tl});
            pe_next[k] = dx * tex;
            pl_next[k] = dx * tlx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            vis_reg  <= in_vis;
            side_reg <= in_side;
            pe_reg   <= pe_next;
            pl_reg   <= pl_next;
        end
    end

    always_comb begin
        out_data = side_reg;
        for (int k = 0; k < AXES; k++) begin
            logic signed [PW-1:0] se, sl;
            se = $signed(pe_reg[k]) >>> F;
            sl = $signed(pl_reg[k]) >>> F;
            if (vis_reg) begin
                out_data[k*C +: C]        = side_reg[k*C +: C] + se[C-1:0];
                out_data[(AXES+k)*C +: C] = side_reg[k*C +: C] + sl[C-1:0];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_vis   = vis_reg;

endmodule

// ===== rtl/line_segment_clipper_3d.sv =====
// line_segment_clipper_3d: liang-barsky clipping of a 3d segment against the unit cube
// depends on lsc_pkg, lsc_div_cell, lsc_edge_cell, lsc_lerp
//
// Takes one segment per cycle while s_tready is high and returns one result per
// segment, in order. A row of PARAM_FRAC_BITS+1 divider cells makes one quotient bit
// per cycle while the pipeline advances, for all six cube faces at once, six cells
// then apply the face tests in order (x low, x high, y low, y high, z low, z high), a
// register stage forms the products d*t and a result register follows. A skid
// register lets a new segment enter while a result waits on m_tready. Quotients are
// truncated toward zero, the clipped endpoints are floored to the coordinate grid,
// and a rejected segment returns its original endpoints with m_tuser low.
module line_segment_clipper_3d #(
    parameter int COORD_WIDTH = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int DATA_W = ((6 * COORD_WIDTH + 32 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, start_color_id, end_color_id
    input  logic [DATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // clip_start_x, clip_start_y, clip_start_z, clip_end_x, clip_end_y, clip_end_z,
    // out_start_color, out_end_color
    output logic [DATA_W-1:0] m_tdata,
    // visible
    output logic              m_tuser
);
    import lsc_pkg::*;

    localparam int C = COORD_WIDTH;
    localparam int F = PARAM_FRAC_BITS;
    localparam int SIDE_W = 6 * C + 2 * COLOR_W;
    localparam int NDIV = F + 1;

    logic adv;

    logic                      dv   [0:NDIV];
    logic [LANES-1:0][C:0]     dden [0:NDIV];
    logic [LANES-1:0][C+1:0]   drem [0:NDIV];
    logic [LANES-1:0][F:0]     dquo [0:NDIV];
    lane_flags_t [LANES-1:0]   dfl  [0:NDIV];
    logic [SIDE_W-1:0]         dside[0:NDIV];

    logic                      ev   [0:LANES];
    logic [LANES-1:0][F:0]     equo [0:LANES];
    lane_flags_t [LANES-1:0]   efl  [0:LANES];
    logic [F:0]                ete  [0:LANES];
    logic [F:0]                etl  [0:LANES];
    logic                      evis [0:LANES];
    logic [SIDE_W-1:0]         eside[0:LANES];

    logic                      lv, lvis;
    logic [SIDE_W-1:0]         ldata;

    logic                      out_valid_reg, skid_valid_reg;
    logic [SIDE_W-1:0]         out_data_reg, skid_data_reg;
    logic                      out_vis_reg, skid_vis_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_comb begin
        dv[0]    = s_tvalid;
        dside[0] = s_tdata[SIDE_W-1:0];
        for (int l = 0; l < LANES; l++) begin
            logic signed [C+1:0] s, e, d, den, num;
            logic [C+1:0]        dm, nm;
            s = $signed(s_tdata[(l/2)*C +: C]);
            e = $signed(s_tdata[(3 + l/2)*C +: C]);
            d = e - s;
            if (l % 2 == 0) begin
                den = d;
                num = -$signed((C+2)'(1) <<< (C - 4)) - s;
            end else begin
                den = -d;
                num = s - $signed((C+2)'(1) <<< (C - 4));
            end
            dm = den[C+1] ? -den : den;
            nm = num[C+1] ? -num : num;
            dden[0][l] = dm[C:0];
            drem[0][l] = nm;
            dquo[0][l] = '0;
            dfl[0][l].den_zero = den == '0;
            dfl[0][l].den_pos  = !den[C+1] && den != '0;
            dfl[0][l].num_pos  = !num[C+1] && num != '0;
            dfl[0][l].neg      = den[C+1] ^ num[C+1];
            dfl[0][l].sat      = nm >= {dm[C:0], 1'b0};
        end
    end

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        lsc_div_cell #(.C(C), .F(F), .SIDE_W(SIDE_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(dv[i]), .in_den(dden[i]), .in_rem(drem[i]), .in_quo(dquo[i]),
            .in_flags(dfl[i]), .in_side(dside[i]),
            .out_valid(dv[i+1]), .out_den(dden[i+1]), .out_rem(drem[i+1]),
            .out_quo(dquo[i+1]), .out_flags(dfl[i+1]), .out_side(dside[i+1])
        );
    end

    assign ev[0]    = dv[NDIV];
    assign equo[0]  = dquo[NDIV];
    assign efl[0]   = dfl[NDIV];
    assign ete[0]   = '0;
    assign etl[0]   = {1'b1, {F{1'b0}}};
    assign evis[0]  = 1'b1;
    assign eside[0] = dside[NDIV];

    for (genvar i = 0; i < LANES; i++) begin : g_edge
        lsc_edge_cell #(.F(F), .SIDE_W(SIDE_W), .IDX(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(ev[i]), .in_quo(equo[i]), .in_flags(efl[i]),
            .in_te(ete[i]), .in_tl(etl[i]), .in_vis(evis[i]), .in_side(eside[i]),
            .out_valid(ev[i+1]), .out_quo(equo[i+1]), .out_flags(efl[i+1]),
            .out_te(ete[i+1]), .out_tl(etl[i+1]), .out_vis(evis[i+1]),
            .out_side(eside[i+1])
        );
    end

    lsc_lerp #(.C(C), .F(F), .SIDE_W(SIDE_W)) u_lerp (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(ev[LANES]), .in_te(ete[LANES]), .in_tl(etl[LANES]),
        .in_vis(evis[LANES]), .in_side(eside[LANES]),
        .out_valid(lv), .out_vis(lvis), .out_data(ldata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (lv) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end

        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_vis_reg  <= skid_vis_reg;
            end
        end else if (lv) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= ldata;
                skid_vis_reg  <= lvis;
            end else begin
                out_data_reg <= ldata;
                out_vis_reg  <= lvis;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_vis_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

endmodule
